/* sv/glob_pattern_matcher_top_assert.svh */
// Assertion macros used by the matcher RTL.
`ifndef GLOB_PATTERN_MATCHER_TOP_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define GPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define GPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define GPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/gpm_pkg.sv */
`timescale 1ns / 1ps

package gpm_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_PATTERN   = 2'd0;
    localparam logic [1:0] KIND_DATA      = 2'd1;
    localparam logic [1:0] KIND_END       = 2'd2;
    localparam logic [1:0] KIND_EMPTY_PAT = 2'd3;

    // Pattern metacharacters.
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ANY   = 8'h3F;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    typedef logic [7:0] t_byte;

endpackage

/* sv/glob_pattern_matcher_top.sv */
`timescale 1ns / 1ps

// Glob matcher: load a pattern of up to PATTERN_MAX bytes (tuser kind 0, tlast on the final
// byte, or kind 3 for the empty pattern), then stream data bytes (kind 1, tlast on the final
// byte of a buffer; kind 2 ends a buffer with no further byte). One result transfer follows
// each end of buffer, with tdata bit 0 = matched and bit 1 = pattern_error ('*' any run,
// '?' any byte, '[...]' literal set, other bytes literal; an unterminated '[' or an
// over-long pattern reports the error). The block takes one item every cycle unless an end
// of buffer stalls behind a waiting result; a result is valid from the clock edge at which
// its item leaves the input register, the edge after the item is accepted when no earlier
// result is waiting. That rate is set by the single-pass update of the active pattern
// position vector between the input register and the result register, where star closure
// and bracket-set scans run as carry chains. While a result waits on the output, only the
// next end of buffer stalls; other items go on. Any pattern item restarts matching and drops
// a buffer in progress. No clearing pass is needed after reset.
module glob_pattern_matcher_top #(
    parameter int PATTERN_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] value
    input  logic [1:0] i_s_tuser,   // [1:0] kind
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] matched, [1] pattern_error, [7:2] zero
);

    `include "glob_pattern_matcher_top_assert.svh"

    localparam int SL = PATTERN_MAX + 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int IW = $clog2(PATTERN_MAX);

    // Input stage.
    logic              r_in_valid;
    logic [1:0]        r_in_kind;
    gpm_pkg::t_byte    r_in_value;
    logic              r_in_last;

    // Pattern state.
    gpm_pkg::t_byte    r_store [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_mem;      // entry lies inside a bracket set
    logic [LW-1:0]     r_len, n_len;
    logic              r_done, n_done;
    logic              r_ovf, n_ovf;
    logic              r_in_br, n_in_br;
    logic [SL-1:0]     r_active, n_active;

    // Result stage.
    logic              r_out_valid;
    logic              r_out_match;
    logic              r_out_err;

    logic              produces;
    logic              adv;

    logic [PATTERN_MAX-1:0] valid_v, star_v, any_v, lit_v, opn_v, cls_v, mem_v, eq_v;
    logic [SL-1:0]     star_x;
    logic [SL-1:0]     sum0;
    logic [PATTERN_MAX-1:0] sum1, sum2;
    logic [SL-1:0]     star_g, reach;
    logic [PATTERN_MAX-1:0] c1, c2, g2;
    logic [PATTERN_MAX-1:0] step;
    logic [SL-1:0]     next_v, eval_v;
    logic [LW-1:0]     len_m1;
    logic              acc;
    logic              err;
    logic [LW-1:0]     eff_len;
    logic              eff_in_br;
    logic              wr_en;

    assign produces = ((r_in_kind == gpm_pkg::KIND_DATA) && r_in_last)
                   || (r_in_kind == gpm_pkg::KIND_END);
    assign adv = r_in_valid && (!produces || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    // Classify every stored entry against the current data byte.
    always_comb begin
        for (int p = 0; p < PATTERN_MAX; p++) begin
            valid_v[p] = r_len > LW'(p);
            star_v[p]  = valid_v[p] && (r_store[p] == gpm_pkg::CH_STAR);
            any_v[p]   = valid_v[p] && (r_store[p] == gpm_pkg::CH_ANY);
            opn_v[p]   = valid_v[p] && (r_store[p] == gpm_pkg::CH_OPEN) && !r_mem[p];
            cls_v[p]   = valid_v[p] && (r_store[p] == gpm_pkg::CH_CLOSE);
            lit_v[p]   = valid_v[p] && (r_store[p] != gpm_pkg::CH_STAR)
                      && (r_store[p] != gpm_pkg::CH_ANY)
                      && (r_store[p] != gpm_pkg::CH_OPEN);
            mem_v[p]   = valid_v[p] && r_mem[p];
            eq_v[p]    = valid_v[p] && (r_store[p] == r_in_value);
        end
    end

    assign star_x = {1'b0, star_v};

    // Each scan is a carry chain with generate G and propagate P: the add of (P | G) and G
    // leaves the carry into bit q as sum ^ (P & ~G).
    // Star closure: a reached '*' also reaches the position after it.
    assign star_g = star_x & r_active;
    assign sum0   = star_x + star_g;
    assign reach  = r_active | (sum0 ^ (star_x & ~r_active));

    // Bracket sets: c1 carries "some member equals the byte" to the closing ']', c2 carries
    // "the opening '[' was reached". A closing ']' never sits past the last entry, so the
    // carry out of the top entry is not needed.
    assign sum1 = mem_v + (mem_v & eq_v);
    assign c1   = sum1 ^ (mem_v & ~eq_v);
    assign g2   = reach[PATTERN_MAX-1:0] & opn_v;
    assign sum2 = (mem_v | g2) + g2;
    assign c2   = sum2 ^ (mem_v & ~g2);

    assign step = (reach[PATTERN_MAX-1:0] & (any_v | (lit_v & eq_v)))
                | (cls_v & c1 & c2);
    assign next_v = (reach & star_x) | {step, 1'b0};

    assign eval_v = (r_in_kind == gpm_pkg::KIND_DATA) ? next_v : r_active;
    assign len_m1 = r_len - LW'(1);
    assign acc = (r_len == '0) || eval_v[r_len]
              || (eval_v[len_m1] && star_v[len_m1[IW-1:0]]);
    assign err = r_ovf || r_in_br;

    assign eff_len   = r_done ? '0 : r_len;
    assign eff_in_br = r_done ? 1'b0 : r_in_br;
    assign wr_en     = adv && (r_in_kind == gpm_pkg::KIND_PATTERN)
                    && (eff_len < LW'(PATTERN_MAX));

    always_comb begin
        n_len    = r_len;
        n_done   = r_done;
        n_ovf    = r_ovf;
        n_in_br  = r_in_br;
        n_active = r_active;
        case (r_in_kind)
            gpm_pkg::KIND_PATTERN: begin
                n_ovf    = r_done ? 1'b0 : r_ovf;
                n_in_br  = eff_in_br;
                n_len    = eff_len;
                if (eff_len < LW'(PATTERN_MAX)) begin
                    n_len = eff_len + LW'(1);
                    if (eff_in_br) begin
                        n_in_br = r_in_value != gpm_pkg::CH_CLOSE;
                    end else begin
                        n_in_br = r_in_value == gpm_pkg::CH_OPEN;
                    end
                end else begin
                    n_ovf = 1'b1;
                end
                n_done   = r_in_last ? 1'b1 : (r_done ? 1'b0 : r_done);
                n_active = SL'(1);
            end
            gpm_pkg::KIND_EMPTY_PAT: begin
                n_len    = '0;
                n_ovf    = 1'b0;
                n_in_br  = 1'b0;
                n_done   = 1'b1;
                n_active = SL'(1);
            end
            gpm_pkg::KIND_DATA: begin
                n_active = r_in_last ? SL'(1) : next_v;
            end
            default: begin
                n_active = SL'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_done      <= 1'b0;
            r_ovf       <= 1'b0;
            r_in_br     <= 1'b0;
            r_active    <= SL'(1);
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (adv) begin
                r_len    <= n_len;
                r_done   <= n_done;
                r_ovf    <= n_ovf;
                r_in_br  <= n_in_br;
                r_active <= n_active;
            end
            if (adv && produces) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_kind  <= i_s_tuser;
            r_in_value <= i_s_tdata;
            r_in_last  <= i_s_tlast;
        end
        if (wr_en) begin
            r_store[eff_len[IW-1:0]] <= r_in_value;
            r_mem[eff_len[IW-1:0]]   <= eff_in_br && (r_in_value != gpm_pkg::CH_CLOSE);
        end
        if (adv && produces) begin
            r_out_match <= !err && acc;
            r_out_err   <= err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_err, r_out_match};

    `GPM_ASSERT_NOW(a_err_no_match, i_clk, i_rst_n, r_out_valid && r_out_err, !r_out_match,
                    "match reported with pattern error")
    `GPM_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, adv && produces, r_out_valid,
                     "end of buffer produced no result")
    `GPM_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(PATTERN_MAX),
                    "pattern length beyond capacity")
    `GPM_ASSERT_NEXT(a_empty_pat, i_clk, i_rst_n,
                     adv && (r_in_kind == gpm_pkg::KIND_EMPTY_PAT),
                     (r_len == '0) && r_done && (r_active == SL'(1)),
                     "empty pattern not loaded")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gpm_pkg::*;

    localparam int PAT_MAX = 32;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 12;

    // Mirrors the matcher: the loaded pattern, the set of live pattern positions, and the
    // verdicts that are owed to the result side.
    class match_scoreboard;
        typedef struct packed {
            logic matched;
            logic pattern_error;
        } verdict_t;

        t_byte          pat_bytes [PAT_MAX];
        int unsigned    pat_len;
        bit             pat_closed;
        bit             pat_overflow;
        bit [PAT_MAX:0] live;
        verdict_t       verdicts_due [$];
        int             failures;

        function new();
            foreach (pat_bytes[i]) pat_bytes[i] = '0;
            pat_len = 0;
            pat_closed = 1'b0;
            pat_overflow = 1'b0;
            failures = 0;
            rewind();
        endfunction

        function void rewind();
            live = '0;
            live[0] = 1'b1;
        endfunction

        // Position of the ']' that closes the bracket at pos, or pat_len if there is none.
        function int unsigned bracket_end(int unsigned pos);
            for (int unsigned j = pos + 1; j < pat_len; j++)
                if (pat_bytes[j] == CH_CLOSE) return j;
            return pat_len;
        endfunction

        function bit pattern_broken();
            int unsigned i;
            int unsigned e;
            if (pat_overflow) return 1'b1;
            i = 0;
            while (i < pat_len) begin
                if (pat_bytes[i] == CH_OPEN) begin
                    e = bracket_end(i);
                    if (e >= pat_len) return 1'b1;
                    i = e + 1;
                end else begin
                    i++;
                end
            end
            return 1'b0;
        endfunction

        function void step_byte(t_byte b);
            bit [PAT_MAX:0] reach;
            bit [PAT_MAX:0] nxt;
            int unsigned e;
            reach = live;
            // A star may match nothing, so it also opens the position after it.
            for (int unsigned p = 0; p < pat_len; p++)
                if (reach[p] && pat_bytes[p] == CH_STAR) reach[p + 1] = 1'b1;
            nxt = '0;
            for (int unsigned p = 0; p < pat_len; p++) begin
                if (!reach[p]) continue;
                if (pat_bytes[p] == CH_STAR) begin
                    nxt[p] = 1'b1;
                end else if (pat_bytes[p] == CH_ANY) begin
                    nxt[p + 1] = 1'b1;
                end else if (pat_bytes[p] == CH_OPEN) begin
                    e = bracket_end(p);
                    if (e < pat_len) begin
                        for (int unsigned j = p + 1; j < e; j++) begin
                            if (pat_bytes[j] == b) begin
                                nxt[e + 1] = 1'b1;
                                break;
                            end
                        end
                    end
                end else if (pat_bytes[p] == b) begin
                    nxt[p + 1] = 1'b1;
                end
            end
            live = nxt;
        endfunction

        function bit at_end_ok();
            if (pat_len == 0) return 1'b1;
            if (live[pat_len]) return 1'b1;
            return live[pat_len - 1] && pat_bytes[pat_len - 1] == CH_STAR;
        endfunction

        function void note_item(logic [1:0] kind, t_byte value, logic last);
            verdict_t v;
            bit closes;
            closes = 1'b0;
            case (kind)
                KIND_PATTERN: begin
                    if (pat_closed) begin
                        pat_len = 0;
                        pat_overflow = 1'b0;
                        pat_closed = 1'b0;
                    end
                    if (pat_len < PAT_MAX) begin
                        pat_bytes[pat_len] = value;
                        pat_len++;
                    end else begin
                        pat_overflow = 1'b1;
                    end
                    if (last) pat_closed = 1'b1;
                    rewind();
                end
                KIND_EMPTY_PAT: begin
                    pat_len = 0;
                    pat_overflow = 1'b0;
                    pat_closed = 1'b1;
                    rewind();
                end
                KIND_DATA: begin
                    step_byte(value);
                    closes = last;
                end
                KIND_END: closes = 1'b1;
                default: closes = 1'b0;
            endcase
            if (closes) begin
                v.pattern_error = pattern_broken();
                v.matched = !v.pattern_error && at_end_ok();
                verdicts_due.push_back(v);
                rewind();
            end
        endfunction

        function void check_verdict(logic [7:0] d);
            verdict_t v;
            if (verdicts_due.size() == 0) begin
                $error("result transfer with no verdict owed: tdata=%h", d);
                failures++;
                return;
            end
            v = verdicts_due.pop_front();
            if (d[0] !== v.matched) begin
                $error("matched: expected %0b, actual %0b", v.matched, d[0]);
                failures++;
            end
            if (d[1] !== v.pattern_error) begin
                $error("pattern_error: expected %0b, actual %0b", v.pattern_error, d[1]);
                failures++;
            end
            if (d[7:2] !== 6'd0) begin
                $error("reserved: expected 0, actual %0h", d[7:2]);
                failures++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data;
    logic [1:0] s_user;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data;

    match_scoreboard sb = new();
    int  accepted = 0;
    int  tx_quiet = 0;
    int  rx_quiet = 0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;

    glob_pattern_matcher_top #(.PATTERN_MAX(PAT_MAX)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),   // [7:0] value
        .i_s_tuser  (s_user),   // [1:0] kind
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)    // [0] matched, [1] pattern_error, [7:2] zero
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap(ref int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A small alphabet keeps literals matching often; the rest covers every byte value.
    function automatic t_byte pick_sym();
        if ($urandom_range(0, 9) < 8) return t_byte'(8'h61 + $urandom_range(0, 2));
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic void make_pattern(ref t_byte pat[$]);
        int pieces;
        int r;
        int n;
        pat.delete();
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                pat.push_back(pick_sym());
            end else if (r < 55) begin
                pat.push_back(CH_ANY);
            end else if (r < 75) begin
                pat.push_back(CH_STAR);
            end else if (r < 96) begin
                pat.push_back(CH_OPEN);
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                repeat (n) pat.push_back(pick_sym());
                pat.push_back(CH_CLOSE);
            end else begin
                pat.push_back(CH_OPEN);
                pat.push_back(pick_sym());
            end
        end
    endfunction

    // Builds a buffer that the pattern would take, then sometimes spoils it.
    function automatic void make_data(ref t_byte pat[$], ref t_byte d[$]);
        int i;
        int e;
        d.delete();
        i = 0;
        while (i < pat.size()) begin
            if (pat[i] == CH_STAR) begin
                repeat ($urandom_range(0, 3)) d.push_back(pick_sym());
                i++;
            end else if (pat[i] == CH_ANY) begin
                d.push_back(pick_sym());
                i++;
            end else if (pat[i] == CH_OPEN) begin
                e = i + 1;
                while (e < pat.size() && pat[e] != CH_CLOSE) e++;
                if (e >= pat.size() || e == i + 1) d.push_back(pick_sym());
                else d.push_back(pat[$urandom_range(i + 1, e - 1)]);
                i = e + 1;
            end else begin
                d.push_back(pat[i]);
                i++;
            end
        end
        case ($urandom_range(0, 9))
            0: if (d.size() > 0) d[$urandom_range(0, d.size() - 1)] = pick_sym();
            1: if (d.size() > 0) void'(d.pop_back());
            2: d.push_back(pick_sym());
            default: ;
        endcase
    endfunction

    task automatic send(input logic [1:0] kind, input t_byte value, input logic last);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user <= kind;
        s_data <= value;
        s_last <= last;
        do @(posedge clk); while (!s_ready);
        sb.note_item(kind, value, last);
        accepted++;
        @(negedge clk);
    endtask

    task automatic load_pattern(ref t_byte pat[$], input bit finish);
        if (pat.size() == 0) begin
            send(KIND_EMPTY_PAT, t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end
        foreach (pat[i]) send(KIND_PATTERN, pat[i], finish && i == pat.size() - 1);
    endtask

    // Ends the buffer by tlast on its final byte or by an end marker; an abandoned buffer
    // is left open so that the next pattern transfer drops it.
    task automatic stream_buffer(ref t_byte d[$], input bit by_marker, input bit abandon);
        if (d.size() == 0 && !abandon) begin
            send(KIND_END, t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            return;
        end
        foreach (d[i]) send(KIND_DATA, d[i], !by_marker && !abandon && i == d.size() - 1);
        if (by_marker && !abandon)
            send(KIND_END, t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_verdict(m_data);
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                // Long hold-off so the block backs up and stalls its input.
                m_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                stall = pick_gap(rx_quiet);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_byte pat [$];
        t_byte buf_bytes [$];
        int    goal;
        int    r;
        int    nbuf;
        s_valid = 1'b0;
        s_data = '0;
        s_user = KIND_PATTERN;
        s_last = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Data before any pattern and an empty buffer: both match the empty pattern.
        send(KIND_DATA, 8'h00, 1'b1);
        send(KIND_END, 8'hFF, 1'b1);
        // Every metacharacter plus the extreme byte values, ending on a star.
        send(KIND_PATTERN, 8'hFF, 1'b0);
        send(KIND_PATTERN, CH_ANY, 1'b0);
        send(KIND_PATTERN, CH_OPEN, 1'b0);
        send(KIND_PATTERN, 8'h00, 1'b0);
        send(KIND_PATTERN, CH_CLOSE, 1'b0);
        send(KIND_PATTERN, CH_STAR, 1'b1);
        send(KIND_DATA, 8'hFF, 1'b0);
        send(KIND_DATA, "A", 1'b0);
        send(KIND_DATA, 8'h00, 1'b1);
        send(KIND_END, 8'h55, 1'b0);
        // A double star left over when the data runs out does not match.
        send(KIND_PATTERN, "a", 1'b0);
        send(KIND_PATTERN, CH_STAR, 1'b0);
        send(KIND_PATTERN, CH_STAR, 1'b1);
        send(KIND_DATA, "a", 1'b1);
        // An empty bracket set never matches.
        send(KIND_PATTERN, CH_OPEN, 1'b0);
        send(KIND_PATTERN, CH_CLOSE, 1'b1);
        send(KIND_DATA, "x", 1'b1);
        // Unterminated bracket reports the error.
        send(KIND_PATTERN, CH_OPEN, 1'b0);
        send(KIND_PATTERN, "a", 1'b1);
        send(KIND_END, 8'h00, 1'b0);
        // Empty pattern, then a buffer closed by an end marker in the middle.
        send(KIND_EMPTY_PAT, 8'hAA, 1'b1);
        send(KIND_DATA, "z", 1'b0);
        send(KIND_END, 8'h00, 1'b1);

        hold_req = 1'b1;
        goal = accepted + RANDOM_ITEMS;
        r = 10;
        while (accepted < goal) begin
            if (r != 10) r = $urandom_range(0, 99);
            if (r < 8) begin
                repeat ($urandom_range(1, 6))
                    send(2'($urandom_range(0, 3)), t_byte'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end else if (r < 12) begin
                // Over-long pattern: bytes past the store are dropped and flagged.
                pat.delete();
                repeat ($urandom_range(PAT_MAX + 1, PAT_MAX + 8))
                    pat.push_back(t_byte'($urandom_range(0, 255)));
                load_pattern(pat, 1'b1);
                repeat ($urandom_range(1, 3)) begin
                    make_data(pat, buf_bytes);
                    stream_buffer(buf_bytes, 1'($urandom_range(0, 1)), 1'b0);
                end
            end else if (r < 16) begin
                // Buffer matched against a pattern that is still being loaded.
                make_pattern(pat);
                load_pattern(pat, 1'b0);
                make_data(pat, buf_bytes);
                stream_buffer(buf_bytes, 1'b0, 1'b0);
            end else begin
                make_pattern(pat);
                if ($urandom_range(0, 99) < 8) pat.delete();
                load_pattern(pat, 1'b1);
                nbuf = $urandom_range(1, 5);
                for (int b = 0; b < nbuf; b++) begin
                    if ($urandom_range(0, 9) == 0) buf_bytes.delete();
                    else make_data(pat, buf_bytes);
                    stream_buffer(buf_bytes, $urandom_range(0, 99) < 15,
                                  b == nbuf - 1 && $urandom_range(0, 99) < 5);
                end
            end
            r = 0;
        end
        s_valid <= 1'b0;

        while (sb.verdicts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/gpm_pkg.sv
sv/glob_pattern_matcher_top.sv
tb/testbench.sv
